>>> hdl/depth_sorted_insert_queue_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the depth sorted insert queue
// Concurrent checks that compile away in synthesis.
// ---------------------------------------------------------------------------
`ifndef DEPTH_SORTED_INSERT_QUEUE_UNIT_DEFINES_SVH
`define DEPTH_SORTED_INSERT_QUEUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define DSIQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DSIQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define DSIQ_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DSIQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/dsiq_pkg.sv
// ---------------------------------------------------------------------------
// dsiq_pkg
// Types and constants shared by the controller and datapath of the queue.
// ---------------------------------------------------------------------------
package dsiq_pkg;

    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 16;
    localparam int DATA_W   = KEY_W + HANDLE_W;

    typedef enum logic [0:0] {
        ST_IDLE  = 1'b0,
        ST_FLUSH = 1'b1
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic insert;   // insert the incoming word into the sorted chain
        logic drop;     // load the incoming word as a dropped result
        logic pop;      // emit the head entry and shift the chain down
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic one_left;
        logic out_free;
    } status_t;

endpackage

>>> hdl/dsiq_ctrl.sv
// ---------------------------------------------------------------------------
// dsiq_ctrl
// Controller: accepts words, decodes push or flush and sequences the flush.
// ---------------------------------------------------------------------------
module dsiq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              action,
    input  dsiq_pkg::status_t status,
    output dsiq_pkg::cmd_t    cmd
);
    import dsiq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && action && !status.empty)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (status.out_free && status.one_left)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        cmd.insert = 1'b0;
        cmd.drop   = 1'b0;
        cmd.pop    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // The output register must be able to take a dropped result.
                s_tready   = status.out_free;
                cmd.insert = s_tvalid && status.out_free && !action && !status.full;
                cmd.drop   = s_tvalid && status.out_free && !action && status.full;
            end
            ST_FLUSH:
            begin
                cmd.pop = status.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

>>> hdl/dsiq_datapath.sv
// ---------------------------------------------------------------------------
// dsiq_datapath
// Sorted shift-register chain of entries plus the output word register.
// ---------------------------------------------------------------------------
module dsiq_datapath #(
    parameter int CAPACITY    = 32,
    parameter int HANDLE_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dsiq_pkg::cmd_t                       cmd,
    output dsiq_pkg::status_t                    status,
    input  logic signed [dsiq_pkg::KEY_W-1:0]    in_key,
    input  logic        [dsiq_pkg::HANDLE_W-1:0] in_handle,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [dsiq_pkg::KEY_W-1:0]    out_key,
    output logic        [dsiq_pkg::HANDLE_W-1:0] out_handle,
    output logic                                 out_last,
    output logic                                 out_drop
);
    import dsiq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SB    = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

    logic signed [KEY_W-1:0] key_reg    [CAPACITY];
    logic signed [KEY_W-1:0] key_next   [CAPACITY];
    logic        [SB-1:0]    handle_reg [CAPACITY];
    logic        [SB-1:0]    handle_next[CAPACITY];

    // Neighbor views of the chain, one per cell.
    logic signed [KEY_W-1:0] prev_key   [CAPACITY];
    logic        [SB-1:0]    prev_handle[CAPACITY];
    logic signed [KEY_W-1:0] succ_key   [CAPACITY];
    logic        [SB-1:0]    succ_handle[CAPACITY];
    logic        [CAPACITY-1:0] gt;
    logic        [CAPACITY-1:0] prev_gt;
    logic        [CAPACITY-1:0] at_end;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [SB-1:0]    in_handle_st;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic signed [KEY_W-1:0] out_key_reg;
    logic [HANDLE_W-1:0]     out_handle_reg;
    logic                    out_last_reg;
    logic                    out_drop_reg;

    assign in_handle_st = in_handle[SB-1:0];

    // A stored entry moves up one place when its key is strictly greater
    // than the new key, which keeps equal keys in arrival order.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            gt[i]     = (CNT_W'(i) < count_reg) && (key_reg[i] > in_key);
            at_end[i] = (CNT_W'(i) == count_reg);
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_link
        if (g == 0)
        begin : g_first
            assign prev_key[g]    = key_reg[g];
            assign prev_handle[g] = handle_reg[g];
            assign prev_gt[g]     = 1'b0;
        end
        else
        begin : g_inner
            assign prev_key[g]    = key_reg[g-1];
            assign prev_handle[g] = handle_reg[g-1];
            assign prev_gt[g]     = gt[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_last
            assign succ_key[g]    = key_reg[g];
            assign succ_handle[g] = handle_reg[g];
        end
        else
        begin : g_body
            assign succ_key[g]    = key_reg[g+1];
            assign succ_handle[g] = handle_reg[g+1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            key_next[i]    = key_reg[i];
            handle_next[i] = handle_reg[i];
            if (cmd.pop)
            begin
                key_next[i]    = succ_key[i];
                handle_next[i] = succ_handle[i];
            end
            else if (cmd.insert)
            begin
                if (prev_gt[i])
                begin
                    key_next[i]    = prev_key[i];
                    handle_next[i] = prev_handle[i];
                end
                else if (gt[i] || at_end[i])
                begin
                    key_next[i]    = in_key;
                    handle_next[i] = in_handle_st;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            key_reg[i]    <= key_next[i];
            handle_reg[i] <= handle_next[i];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.full     = (count_reg == CNT_W'(CAPACITY));
    assign status.empty    = (count_reg == '0);
    assign status.one_left = (count_reg == CNT_W'(1));
    assign status.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.pop || cmd.drop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            out_key_reg    <= key_reg[0];
            out_handle_reg <= HANDLE_W'(handle_reg[0]);
            out_last_reg   <= status.one_left;
            out_drop_reg   <= 1'b0;
        end
        else if (cmd.drop)
        begin
            out_key_reg    <= in_key;
            out_handle_reg <= HANDLE_W'(in_handle_st);
            out_last_reg   <= 1'b0;
            out_drop_reg   <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_key    = out_key_reg;
    assign out_handle = out_handle_reg;
    assign out_last   = out_last_reg;
    assign out_drop   = out_drop_reg;

endmodule

>>> hdl/depth_sorted_insert_queue_unit.sv
// Push: taken at the handshake; a push onto a full list shows its dropped word in the next cycle.
// Throughput: one push per cycle while the output register is free to take a word.
// Flush of N entries: acceptance moves the controller into its flush state, which then pops
// head entries into the output register, one per cycle while m_tready stays high; no input
// word is taken until the last one has been loaded into the output register.
// Reset (rst_n low, asynchronous): the list is emptied and the output word is invalid.
// ---------------------------------------------------------------------------
// depth_sorted_insert_queue_unit
// Stable insertion-sort queue of item handles ordered by a signed depth key.
// ---------------------------------------------------------------------------
`include "depth_sorted_insert_queue_unit_defines.svh"

module depth_sorted_insert_queue_unit #(
    parameter int CAPACITY    = 32,
    parameter int HANDLE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // [31:0] depth_key, [47:32] item_handle
    input  logic        s_tuser,    // [0] action: 0 push, 1 flush
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [15:0] out_handle, [47:16] out_key
    output logic        m_tlast,    // last_flag
    output logic        m_tuser     // [0] dropped
);
    import dsiq_pkg::*;

    // The list lives in a chain of registers held in ascending key order.
    // A push compares the new key against every stored entry at once; all
    // entries with a strictly greater key move up one place and the new
    // entry lands in the gap. A flush pops the head entry into the output
    // register each cycle that it is free and shifts the chain down, so
    // entries leave in ascending order.

    cmd_t    cmd;
    status_t status;

    logic signed [KEY_W-1:0]    in_key;
    logic        [HANDLE_W-1:0] in_handle;
    logic signed [KEY_W-1:0]    out_key;
    logic        [HANDLE_W-1:0] out_handle;

    assign in_key    = $signed(s_tdata[KEY_W-1:0]);
    assign in_handle = s_tdata[DATA_W-1:KEY_W];

    // The controller owns the handshake and the flush sequence.
    dsiq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .action   (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the sorted chain, the entry count and the output word.
    dsiq_datapath #(
        .CAPACITY    (CAPACITY),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_key     (in_key),
        .in_handle  (in_handle),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_key    (out_key),
        .out_handle (out_handle),
        .out_last   (m_tlast),
        .out_drop   (m_tuser)
    );

    assign m_tdata = {out_key, out_handle};

    // A rejected push must come out as a dropped word in the next cycle.
    `DSIQ_ASSERT_NEXT(a_drop_shows, clk, rst_n, cmd.drop, m_tvalid && m_tuser && !m_tlast)
    // Popping the final entry leaves the list empty and marks the word as last.
    `DSIQ_ASSERT_NEXT(a_flush_ends, clk, rst_n, cmd.pop && status.one_left, status.empty && m_tlast)
    // A stored push always leaves at least one entry behind.
    `DSIQ_ASSERT_NEXT(a_insert_fills, clk, rst_n, cmd.insert, !status.empty)
    // Only one command may be issued at a time.
    `DSIQ_ASSERT_SAME(a_one_cmd, clk, rst_n, cmd.insert || cmd.drop || cmd.pop, $onehot(cmd))

endmodule

>>> tb/sv/depth_sorted_insert_queue_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// depth_sorted_insert_queue_unit_tb
// Self-checking bench for the depth sorted insert queue. A short directed
// table covers the key extremes, stable ordering of equal keys, flushes of
// empty and full lists and pushes onto a full list. Random push bursts
// mostly closed by flushes follow. Every accepted input word goes
// through a behavioral sorted list. Every output word is compared with
// the oldest expected word. Both stream sides idle at random.
// ---------------------------------------------------------------------------
module depth_sorted_insert_queue_unit_tb;

    import dsiq_pkg::*;

    localparam realtime CLK_PERIOD  = 12.0;
    localparam int      CAPACITY    = 32;
    localparam int      HANDLE_BITS = 16;
    localparam int      WATCHDOG_CYCLES = 600_000;

    // Action codes carried on s_tuser.
    localparam logic ACT_PUSH  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    localparam logic [HANDLE_W-1:0] HANDLE_MASK = HANDLE_W'((64'd1 << HANDLE_BITS) - 1);

    localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;

    // One output word, split into its fields.
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key;
        logic                last;
        logic                dropped;
    } word_t;

    // One row of the directed table. A row with reps above one pushes that
    // many words with small random keys, so that the list fills up. A row
    // with typed set carries its expectation by hand: none, or one word.
    typedef struct packed {
        logic                act;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] hdl;
        logic [7:0]          reps;
        logic                typed;
        logic                typed_n;
        word_t               typed_w;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata = '0;
    logic                s_tuser = ACT_PUSH;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [DATA_W-1:0]   m_tdata;
    logic                m_tlast;
    logic                m_tuser;

    // Behavioral copy of the sorted list.
    logic [KEY_W-1:0]    list_keys    [CAPACITY];
    logic [HANDLE_W-1:0] list_handles [CAPACITY];
    int                  list_count = 0;

    word_t               step_words[$];     // words caused by the last accepted input
    word_t               pending_words[$];  // words still owed by the block
    int                  bad_words = 0;

    // Idle rates in percent, changed per phase by the stimulus process.
    int                  send_gap_pct   = 11;
    int                  recv_stall_pct = 83;

    depth_sorted_insert_queue_unit #(
        .CAPACITY    (CAPACITY),
        .HANDLE_BITS (HANDLE_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Applies one accepted input word to the sorted list and leaves the
    // words it causes in step_words. A push walks up from the tail past
    // every entry with a strictly greater key, so equal keys stay in
    // arrival order.
    function automatic void sorted_list_apply(input logic act, input logic [KEY_W-1:0] key,
                                              input logic [HANDLE_W-1:0] hdl);
        int                  pos;
        logic [HANDLE_W-1:0] stored;
        stored = hdl & HANDLE_MASK;
        step_words.delete();
        if (act == ACT_PUSH) begin
            if (list_count >= CAPACITY) begin
                step_words.push_back({stored, key, 1'b0, 1'b1});
            end
            else begin
                pos = list_count;
                while (pos > 0 && $signed(list_keys[pos - 1]) > $signed(key)) begin
                    list_keys[pos]    = list_keys[pos - 1];
                    list_handles[pos] = list_handles[pos - 1];
                    pos--;
                end
                list_keys[pos]    = key;
                list_handles[pos] = stored;
                list_count++;
            end
        end
        else begin
            for (int i = 0; i < list_count; i++) begin
                step_words.push_back({list_handles[i], list_keys[i],
                                      (i == list_count - 1) ? 1'b1 : 1'b0, 1'b0});
            end
            list_count = 0;
        end
    endfunction

    function automatic stim_row_t row(input logic act, input logic [KEY_W-1:0] key,
                                      input logic [HANDLE_W-1:0] hdl, input int reps,
                                      input logic typed, input logic typed_n,
                                      input word_t typed_w);
        row = {act, key, hdl, 8'(reps), typed, typed_n, typed_w};
    endfunction

    // Offers one input word, waits for the handshake, then books the
    // words it should cause. Valid is only lowered while a gap is taken,
    // so back-to-back words keep it high without a glitch.
    task automatic put_word(input logic act, input logic [KEY_W-1:0] key,
                            input logic [HANDLE_W-1:0] hdl, input logic typed,
                            input logic typed_n, input word_t typed_w);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {hdl, key};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sorted_list_apply(act, key, hdl);
        if (typed) begin
            if (typed_n) pending_words.push_back(typed_w);
        end
        else begin
            foreach (step_words[i]) pending_words.push_back(step_words[i]);
        end
    endtask

    // Output side: check each accepted word against the oldest expectation,
    // then pick the ready level for the next cycle. Values seen here are
    // the ones the block saw at this edge.
    always @(posedge clk) begin
        word_t got;
        word_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got = {m_tdata[15:0], m_tdata[47:16], m_tlast, m_tuser};
            if (pending_words.size() == 0) begin
                bad_words++;
                if (bad_words <= 10)
                    $display("unexpected word: handle %h key %h last %b dropped %b",
                             got.handle, got.key, got.last, got.dropped);
            end
            else begin
                want = pending_words.pop_front();
                if (got.handle !== want.handle || got.key !== want.key ||
                    got.last !== want.last || got.dropped !== want.dropped) begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display({"mismatch: expected handle %h key %h last %b dropped %b, ",
                                  "got handle %h key %h last %b dropped %b"},
                                 want.handle, want.key, want.last, want.dropped,
                                 got.handle, got.key, got.last, got.dropped);
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin
        stim_row_t          directed[$];
        stim_row_t          r;
        int                 phase_items;
        int                 burst_len;
        logic [KEY_W-1:0]   key;
        word_t              none;

        none = '0;

        // Directed table. Rows with a typed expectation are those whose
        // outcome is plain: empty flushes, single extreme entries, drops.
        directed.push_back(row(ACT_FLUSH, '0, '0, 1, 1'b1, 1'b0, none));
        directed.push_back(row(ACT_PUSH, KEY_MAX, 16'hFFFF, 1, 1'b0, 1'b0, none));
        directed.push_back(row(ACT_FLUSH, '0, '0, 1, 1'b1, 1'b1,
                               {16'hFFFF, KEY_MAX, 1'b1, 1'b0}));
        directed.push_back(row(ACT_PUSH, KEY_MIN, 16'h0000, 1, 1'b0, 1'b0, none));
        directed.push_back(row(ACT_FLUSH, '0, '0, 1, 1'b1, 1'b1,
                               {16'h0000, KEY_MIN, 1'b1, 1'b0}));
        // Mixed signs and repeated keys, so stable ordering shows up.
        directed.push_back(row(ACT_PUSH, 32'd5, 16'h0001, 1, 1'b0, 1'b0, none));
        directed.push_back(row(ACT_PUSH, -32'sd3, 16'h0002, 1, 1'b0, 1'b0, none));
        directed.push_back(row(ACT_PUSH, 32'd5, 16'h0003, 1, 1'b0, 1'b0, none));
        directed.push_back(row(ACT_PUSH, 32'd0, 16'h0004, 1, 1'b0, 1'b0, none));
        directed.push_back(row(ACT_PUSH, KEY_MIN, 16'h0005, 1, 1'b0, 1'b0, none));
        directed.push_back(row(ACT_PUSH, KEY_MAX, 16'h0006, 1, 1'b0, 1'b0, none));
        directed.push_back(row(ACT_PUSH, -32'sd3, 16'h0007, 1, 1'b0, 1'b0, none));
        directed.push_back(row(ACT_FLUSH, '0, '0, 1, 1'b0, 1'b0, none));
        // Fill the list, then push onto it while full: each push is dropped.
        directed.push_back(row(ACT_PUSH, '0, 16'h0100, CAPACITY, 1'b0, 1'b0, none));
        directed.push_back(row(ACT_PUSH, 32'h1234_5678, 16'hABCD, 1, 1'b1, 1'b1,
                               {16'hABCD, 32'h1234_5678, 1'b0, 1'b1}));
        directed.push_back(row(ACT_PUSH, KEY_MIN, 16'hFFFF, 1, 1'b1, 1'b1,
                               {16'hFFFF, KEY_MIN, 1'b0, 1'b1}));
        directed.push_back(row(ACT_PUSH, KEY_MAX, 16'h0000, 1, 1'b1, 1'b1,
                               {16'h0000, KEY_MAX, 1'b0, 1'b1}));
        directed.push_back(row(ACT_FLUSH, '0, '0, 1, 1'b0, 1'b0, none));
        directed.push_back(row(ACT_FLUSH, '0, '0, 1, 1'b1, 1'b0, none));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i]) begin
            r = directed[i];
            if (r.reps > 1) begin
                for (int n = 0; n < r.reps; n++)
                    put_word(r.act, $urandom_range(0, 15) - 32'd8, r.hdl + 16'(n),
                             1'b0, 1'b0, none);
            end
            else begin
                put_word(r.act, r.key, r.hdl, r.typed, r.typed_n, r.typed_w);
            end
        end

        // Random part in three idle phases: sender mostly busy and receiver
        // mostly stalled, then the reverse, then no idling on either side.
        for (int phase = 0; phase < 3; phase++) begin
            send_gap_pct   = (phase == 0) ? 11 : (phase == 1) ? 83 : 0;
            recv_stall_pct = (phase == 0) ? 83 : (phase == 1) ? 11 : 0;
            phase_items    = 0;
            while (phase_items < 50) begin
                // Mostly short bursts, sometimes an empty flush, sometimes
                // enough pushes to overflow the list.
                case ($urandom_range(0, 9))
                    0:       burst_len = 0;
                    1:       burst_len = $urandom_range(CAPACITY, CAPACITY + 4);
                    default: burst_len = $urandom_range(1, 12);
                endcase
                for (int n = 0; n < burst_len; n++) begin
                    case ($urandom_range(0, 3))
                        0: key = $urandom_range(0, 7) - 32'd4;
                        1: begin
                            case ($urandom_range(0, 3))
                                0:       key = KEY_MIN;
                                1:       key = KEY_MAX;
                                2:       key = '0;
                                default: key = '1;
                            endcase
                        end
                        default: key = $urandom;
                    endcase
                    put_word(ACT_PUSH, key, 16'($urandom), 1'b0, 1'b0, none);
                    phase_items++;
                end
                // Now and then the list is left standing into the next burst.
                if ($urandom_range(0, 7) != 0) begin
                    put_word(ACT_FLUSH, $urandom, 16'($urandom), 1'b0, 1'b0, none);
                    phase_items++;
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        // Leave room for any stray word the block might still emit.
        repeat (40) @(posedge clk);
        if (bad_words == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #(WATCHDOG_CYCLES * CLK_PERIOD);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
